// ----- src/sdx_pkg.sv -----
// Shared types, constants and the letter-group lookup for the phonetic word matcher.
// No dependencies; used by every other file of the block.
`default_nettype none

package sdx_pkg;

   // Text size limit and derived widths
   localparam int MAX_TEXT  = 4096;
   localparam int CHAR_W    = 8;
   localparam int DIGIT_W   = 3;
   localparam int START_W   = 12;
   localparam int LEN_W     = 13;
   localparam int POS_W     = $clog2(MAX_TEXT + 1);
   localparam int START_MAX = (MAX_TEXT - 1 < 4095) ? MAX_TEXT - 1 : 4095;
   localparam int LEN_MAX   = (MAX_TEXT < 4096) ? MAX_TEXT : 4096;

   // Configuration register indexes
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_INITIAL     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_DIGIT_ONE   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_DIGIT_TWO   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_DIGIT_THREE = 4'd3;

   typedef struct packed {
      logic [CHAR_W-1:0]  initial_char;
      logic [DIGIT_W-1:0] digit_one;
      logic [DIGIT_W-1:0] digit_two;
      logic [DIGIT_W-1:0] digit_three;
   } key_type;

   typedef struct packed {
      logic               is_letter;
      logic [CHAR_W-1:0]  lower;
      logic [DIGIT_W-1:0] digit;
   } char_class_type;

   typedef struct packed {
      logic               word_valid;
      logic               word_match;
      logic [START_W-1:0] word_start;
      logic [LEN_W-1:0]   word_length;
      logic               any_match;
      logic               text_done;
   } result_type;

   // Letter group digit of a lowercase letter, zero for letters without a group
   function automatic logic [DIGIT_W-1:0] group_digit(input logic [CHAR_W-1:0] c);
      logic [DIGIT_W-1:0] d;
      case (c)
         "b", "f", "p", "v": d = 3'd1;
         "c", "g", "j", "k", "q", "s", "x", "z": d = 3'd2;
         "d", "t": d = 3'd3;
         "l": d = 3'd4;
         "m", "n": d = 3'd5;
         "r": d = 3'd6;
         default: d = 3'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// ----- src/sdx_if.sv -----
// Channel interfaces of the phonetic word matcher: character input, result output
// and register write. Depends on sdx_pkg.
`default_nettype none

interface sdx_req_if;
   logic                      valid;
   logic                      ready;
   logic [sdx_pkg::CHAR_W-1:0] text_char;
   logic                      text_end;
   modport source (output valid, output text_char, output text_end, input ready);
   modport sink (input valid, input text_char, input text_end, output ready);
endinterface

interface sdx_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       word_valid;
   logic                       word_match;
   logic [sdx_pkg::START_W-1:0] word_start;
   logic [sdx_pkg::LEN_W-1:0]   word_length;
   logic                       any_match;
   logic                       text_done;
   modport source (output valid, output word_valid, output word_match, output word_start,
                   output word_length, output any_match, output text_done, input ready);
   modport sink (input valid, input word_valid, input word_match, input word_start,
                 input word_length, input any_match, input text_done, output ready);
endinterface

interface sdx_csr_if;
   logic                          valid;
   logic                          ready;
   logic [sdx_pkg::CSR_IDX_W-1:0] reg_index;
   logic [sdx_pkg::CHAR_W-1:0]    wr_data;
   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

// ----- src/soundex_word_matcher.sv -----
// Top level of the phonetic word matcher: input register, key registers,
// output register. Depends on sdx_pkg, sdx_if, sdx_char_class, sdx_word_core.
//
// Usage:
//  - req_bus carries one text character per transaction (text_char, text_end).
//    Letters build words; any other character closes the current word.
//  - rsp_bus carries at most one result per character: a closed word with its
//    start, length and key match, and/or the text_done mark with any_match.
//  - csr_bus writes the key code (index 0 initial, 1..3 digits); always ready.
//    Write it only while no character is in flight.
//  - A character waits in the input register until the output register is free,
//    and its result, if any, is then registered there. Throughput: one character
//    per cycle while rsp_bus is not stalled; the path is combinational, nothing iterates.
//  - The input register can still take a character while a result waits in the
//    output register; when the receiver stalls with both registers full,
//    req_bus.ready drops until the output register drains.
//  - Reset clears the word state, the key and the valid flags of both registers; no warm-up pass.
`default_nettype none

module soundex_word_matcher (
   input wire logic clock,
   input wire logic reset,
   sdx_req_if.sink   req_bus,
   sdx_rsp_if.source rsp_bus,
   sdx_csr_if.sink   csr_bus
);

   logic                       in_valid_ff, in_valid_in;
   logic [sdx_pkg::CHAR_W-1:0] in_char_ff;
   logic                       in_end_ff;
   logic                       out_valid_ff, out_valid_in;
   sdx_pkg::result_type        out_data_ff;
   sdx_pkg::key_type           key_ff;
   sdx_pkg::char_class_type    char_class;
   sdx_pkg::result_type        result;
   logic                       emit;
   logic                       out_free;
   logic                       advance;

   // Handshake control
   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign advance       = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || advance;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) in_valid_in = 1'b0;
      if (req_bus.valid && req_bus.ready) in_valid_in = 1'b1;
      out_valid_in = out_valid_ff;
      if (rsp_bus.ready) out_valid_in = 1'b0;
      if (advance) out_valid_in = emit;
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the incoming character and the result payload
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_char_ff <= req_bus.text_char;
         in_end_ff  <= req_bus.text_end;
      end
      if (advance && emit) out_data_ff <= result;
   end

   // Key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.reg_index)
            sdx_pkg::REG_KEY_INITIAL:     key_ff.initial_char <= csr_bus.wr_data;
            sdx_pkg::REG_KEY_DIGIT_ONE:   key_ff.digit_one   <= csr_bus.wr_data[2:0];
            sdx_pkg::REG_KEY_DIGIT_TWO:   key_ff.digit_two   <= csr_bus.wr_data[2:0];
            sdx_pkg::REG_KEY_DIGIT_THREE: key_ff.digit_three <= csr_bus.wr_data[2:0];
            default: key_ff <= key_ff;
         endcase
      end
   end

   sdx_char_class u_class (
      .text_char  (in_char_ff),
      .char_class (char_class)
   );

   sdx_word_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .char_class (char_class),
      .text_end   (in_end_ff),
      .key        (key_ff),
      .emit       (emit),
      .result     (result)
   );

   // Drive the result channel
   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.word_valid  = out_data_ff.word_valid;
   assign rsp_bus.word_match  = out_data_ff.word_match;
   assign rsp_bus.word_start  = out_data_ff.word_start;
   assign rsp_bus.word_length = out_data_ff.word_length;
   assign rsp_bus.any_match   = out_data_ff.any_match;
   assign rsp_bus.text_done   = out_data_ff.text_done;

`ifndef ASSERT_OFF
   a_word_has_letters: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.word_valid |-> out_data_ff.word_length != '0)
      else $error("reported word has no letters");
   a_match_needs_word: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_data_ff.word_valid |-> !out_data_ff.word_match &&
      out_data_ff.text_done && out_data_ff.word_length == '0)
      else $error("result without a word is not a bare end of text");
   a_match_sets_any: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.word_match |-> out_data_ff.any_match)
      else $error("word match not reflected in any_match");
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_char_ff))
      else $error("pending character lost while output stalled");
`endif

endmodule

`default_nettype wire

// ----- src/sdx_char_class.sv -----
// Character classifier: letter test, lowercase and letter-group digit.
// Depends on sdx_pkg.
`default_nettype none

module sdx_char_class (
   input  wire logic [sdx_pkg::CHAR_W-1:0] text_char,
   output sdx_pkg::char_class_type        char_class
);

   logic upper;
   logic lower;

   // Classify ASCII letters, fold case, look up the group
   always_comb begin
      upper = (text_char >= "A") && (text_char <= "Z");
      lower = (text_char >= "a") && (text_char <= "z");
      char_class.is_letter = upper || lower;
      char_class.lower     = upper ? (text_char | 8'h20) : text_char;
      char_class.digit     = sdx_pkg::group_digit(char_class.lower);
   end

endmodule

`default_nettype wire

// ----- src/sdx_word_core.sv -----
// Word state and code builder: tracks the current word, its code, position and
// match flag, and forms the result of one character. Depends on sdx_pkg.
`default_nettype none

module sdx_word_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire sdx_pkg::char_class_type char_class,
   input  wire logic                   text_end,
   input  wire sdx_pkg::key_type       key,
   output logic                        emit,
   output sdx_pkg::result_type         result
);

   localparam int PW = sdx_pkg::POS_W;
   localparam int SW = sdx_pkg::START_W;
   localparam int LW = sdx_pkg::LEN_W;
   localparam int DW = sdx_pkg::DIGIT_W;

   logic                        in_word_ff, in_word_in;
   logic [sdx_pkg::CHAR_W-1:0]  initial_ff, initial_in;
   logic [DW-1:0]               code_ff [3];
   logic [DW-1:0]               code_in [3];
   logic [1:0]                  kept_ff, kept_in;
   logic [DW-1:0]               last_ff, last_in;
   logic [PW-1:0]               pos_ff, pos_in;
   logic [SW-1:0]               start_ff, start_in;
   logic                        any_ff, any_in;
   logic [LW-1:0]               count_ff, count_in;
   logic                        match;
   logic                        word_close;

   // Build the next word state and the result of this character
   always_comb begin
      in_word_in = in_word_ff;
      initial_in = initial_ff;
      code_in    = code_ff;
      kept_in    = kept_ff;
      last_in    = last_ff;
      start_in   = start_ff;
      count_in   = count_ff;
      any_in     = any_ff;
      pos_in     = (pos_ff < PW'(sdx_pkg::MAX_TEXT)) ? pos_ff + 1'b1 : pos_ff;

      if (char_class.is_letter) begin
         if (!in_word_ff) begin
            // open a new word
            in_word_in = 1'b1;
            initial_in = char_class.lower;
            code_in[0] = '0;
            code_in[1] = '0;
            code_in[2] = '0;
            kept_in    = 2'd0;
            last_in    = '0;
            start_in   = (pos_ff > PW'(sdx_pkg::START_MAX)) ?
                         SW'(sdx_pkg::START_MAX) : pos_ff[SW-1:0];
            count_in   = LW'(1);
         end else begin
            if (count_ff < LW'(sdx_pkg::LEN_MAX)) count_in = count_ff + 1'b1;
            // keep a group digit unless it repeats the last kept one
            if (kept_ff != 2'd3 && char_class.digit != '0 && char_class.digit != last_ff) begin
               case (kept_ff)
                  2'd0: code_in[0] = char_class.digit;
                  2'd1: code_in[1] = char_class.digit;
                  2'd2: code_in[2] = char_class.digit;
                  default: code_in[0] = code_ff[0];
               endcase
               kept_in = kept_ff + 2'd1;
               last_in = char_class.digit;
            end
         end
      end

      word_close = in_word_in && (!char_class.is_letter || text_end);
      match = word_close && (initial_in == key.initial_char) &&
              (code_in[0] == key.digit_one) && (code_in[1] == key.digit_two) &&
              (code_in[2] == key.digit_three);
      if (match) any_in = 1'b1;
      if (word_close) in_word_in = 1'b0;

      emit               = word_close || text_end;
      result.word_valid  = word_close;
      result.word_match  = match;
      result.word_start  = word_close ? start_in : '0;
      result.word_length = word_close ? count_in : '0;
      result.any_match   = any_in;
      result.text_done   = text_end;

      // clear per-text state after the closing character
      if (text_end) begin
         in_word_in = 1'b0;
         initial_in = '0;
         code_in[0] = '0;
         code_in[1] = '0;
         code_in[2] = '0;
         kept_in    = 2'd0;
         last_in    = '0;
         pos_in     = '0;
         start_in   = '0;
         any_in     = 1'b0;
         count_in   = '0;
      end
   end

   // Advance the word state once per processed character
   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff <= 1'b0;
         initial_ff <= '0;
         code_ff[0] <= '0;
         code_ff[1] <= '0;
         code_ff[2] <= '0;
         kept_ff    <= 2'd0;
         last_ff    <= '0;
         pos_ff     <= '0;
         start_ff   <= '0;
         any_ff     <= 1'b0;
         count_ff   <= '0;
      end else if (advance) begin
         in_word_ff <= in_word_in;
         initial_ff <= initial_in;
         code_ff    <= code_in;
         kept_ff    <= kept_in;
         last_ff    <= last_in;
         pos_ff     <= pos_in;
         start_ff   <= start_in;
         any_ff     <= any_in;
         count_ff   <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_end_clears_pos: assert property (@(posedge clock) disable iff (reset)
      advance && text_end |=> pos_ff == '0 && !in_word_ff && !any_ff)
      else $error("text state not cleared after closing character");
   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PW'(sdx_pkg::MAX_TEXT))
      else $error("character position beyond saturation");
`endif

endmodule

`default_nettype wire

// ----- tb/sdx_match_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the phonetic word matcher: mirrors the key and word state,
// predicts each result and compares it with the rsp channel. Depends on sdx_pkg, sdx_if.

module sdx_match_checker (
   input  wire logic clock,
   input  wire logic reset,
   sdx_req_if        req_mon,
   sdx_rsp_if        rsp_mon,
   sdx_csr_if        csr_mon,
   output int        error_count,
   output int        results_pending
);

   localparam int CHAR_W    = sdx_pkg::CHAR_W;
   localparam int DIGIT_W   = sdx_pkg::DIGIT_W;
   localparam int POS_W     = sdx_pkg::POS_W;
   localparam int START_W   = sdx_pkg::START_W;
   localparam int LEN_W     = sdx_pkg::LEN_W;
   localparam int MAX_TEXT  = sdx_pkg::MAX_TEXT;
   localparam int START_MAX = sdx_pkg::START_MAX;
   localparam int LEN_MAX   = sdx_pkg::LEN_MAX;

   // Group code per letter a..z, first character is 'a'
   localparam logic [8*26-1:0] GROUP_TABLE = "01230120022455012623010202";

   // Mirrored key and per-text state
   sdx_pkg::key_type       key;
   logic                   in_word;
   logic [CHAR_W-1:0]      word_init;
   logic [DIGIT_W-1:0]     code_q [3];
   logic [1:0]             kept;
   logic [DIGIT_W-1:0]     last_code;
   logic [POS_W-1:0]       char_pos;
   logic [START_W-1:0]     start_q;
   logic [LEN_W-1:0]       letter_cnt;
   logic                   any_hit;
   sdx_pkg::result_type    expected_words [$];
   int                     shown;

   function automatic logic [DIGIT_W-1:0] group_code(input logic [CHAR_W-1:0] lc);
      int                idx;
      logic [CHAR_W-1:0] glyph;
      idx   = lc - "a";
      glyph = GROUP_TABLE[8*(25-idx) +: 8];
      return DIGIT_W'(glyph - "0");
   endfunction

   function automatic string fmt_result(input sdx_pkg::result_type r);
      return $sformatf("valid=%0b match=%0b start=%0d len=%0d any=%0b done=%0b",
                       r.word_valid, r.word_match, r.word_start, r.word_length,
                       r.any_match, r.text_done);
   endfunction

   task automatic clear_text();
      in_word    = 1'b0;
      word_init  = '0;
      code_q     = '{default: '0};
      kept       = '0;
      last_code  = '0;
      char_pos   = '0;
      start_q    = '0;
      letter_cnt = '0;
      any_hit    = 1'b0;
   endtask

   // Advance the word state by one character; emit tells whether a result follows
   task automatic predict_char(input logic [CHAR_W-1:0] ch, input logic fin,
                               output bit emit, output sdx_pkg::result_type res);
      logic               letter;
      logic [CHAR_W-1:0]  lc;
      logic [DIGIT_W-1:0] d;
      logic [POS_W-1:0]   pos;
      logic               hit;
      letter = (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
      lc     = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
      pos    = char_pos;
      emit   = 1'b0;
      res    = '0;
      if (pos < MAX_TEXT)
         char_pos = pos + 1'b1;

      if (letter) begin
         if (!in_word) begin
            in_word    = 1'b1;
            word_init  = lc;
            code_q     = '{default: '0};
            kept       = '0;
            last_code  = '0;
            start_q    = (pos > START_MAX) ? START_W'(START_MAX) : START_W'(pos);
            letter_cnt = LEN_W'(1);
         end else begin
            d = group_code(lc);
            if (letter_cnt < LEN_MAX)
               letter_cnt = letter_cnt + 1'b1;
            // repeats of the last kept code are dropped, vowels do not separate them
            if (kept < 3 && d != 0 && d != last_code) begin
               code_q[kept] = d;
               kept         = kept + 1'b1;
               last_code    = d;
            end
         end
      end

      if (in_word && (!letter || fin)) begin
         hit = word_init == key.initial_char && code_q[0] == key.digit_one &&
               code_q[1] == key.digit_two && code_q[2] == key.digit_three;
         if (hit)
            any_hit = 1'b1;
         emit            = 1'b1;
         res.word_valid  = 1'b1;
         res.word_match  = hit;
         res.word_start  = start_q;
         res.word_length = letter_cnt;
         in_word         = 1'b0;
      end else if (fin) begin
         emit = 1'b1;
      end
      res.any_match = any_hit;
      res.text_done = fin;

      if (fin)
         clear_text();
   endtask

   // Watch all three channels at the rising edge
   always @(posedge clock) begin : watch
      bit                  emit;
      sdx_pkg::result_type want;
      sdx_pkg::result_type got;
      if (reset) begin
         key = '0;
         clear_text();
         expected_words.delete();
         error_count = 0;
         shown       = 0;
      end else begin
         // Track key register writes
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.reg_index)
               sdx_pkg::REG_KEY_INITIAL:     key.initial_char = csr_mon.wr_data;
               sdx_pkg::REG_KEY_DIGIT_ONE:   key.digit_one    = csr_mon.wr_data[DIGIT_W-1:0];
               sdx_pkg::REG_KEY_DIGIT_TWO:   key.digit_two    = csr_mon.wr_data[DIGIT_W-1:0];
               sdx_pkg::REG_KEY_DIGIT_THREE: key.digit_three  = csr_mon.wr_data[DIGIT_W-1:0];
               default: ;
            endcase
         end

         // Queue the prediction for each accepted character
         if (req_mon.valid && req_mon.ready) begin
            predict_char(req_mon.text_char, req_mon.text_end, emit, want);
            if (emit)
               expected_words.push_back(want);
         end

         // Compare each accepted result with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.word_valid  = rsp_mon.word_valid;
            got.word_match  = rsp_mon.word_match;
            got.word_start  = rsp_mon.word_start;
            got.word_length = rsp_mon.word_length;
            got.any_match   = rsp_mon.any_match;
            got.text_done   = rsp_mon.text_done;
            if (expected_words.size() == 0) begin
               error_count++;
               if (shown < 10) begin
                  shown++;
                  $display("%0t unexpected result: %s", $realtime, fmt_result(got));
               end
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (shown < 10) begin
                     shown++;
                     $display("%0t result mismatch: expected %s", $realtime,
                              fmt_result(want));
                     $display("%0t                  actual   %s", $realtime,
                              fmt_result(got));
                  end
               end
            end
         end
      end
      results_pending = expected_words.size();
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the phonetic word matcher testbench: clock, reset, key writes and text
// stimulus with random gaps and stalls. Depends on sdx_pkg, sdx_if, sdx_match_checker.

module tb_top;

   localparam int CHAR_W       = sdx_pkg::CHAR_W;
   localparam int DIGIT_W      = sdx_pkg::DIGIT_W;
   localparam int CSR_IDX_W    = sdx_pkg::CSR_IDX_W;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PHASE_CHARS  = 60;
   localparam int RANDOM_PHASES = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sdx_req_if req_bus ();
   sdx_rsp_if rsp_bus ();
   sdx_csr_if csr_bus ();

   int error_count;
   int results_pending;

   soundex_word_matcher dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   sdx_match_checker match_chk (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_mon         (csr_bus),
      .error_count     (error_count),
      .results_pending (results_pending)
   );

   // Letters per code group, group 0 holds the letters that give no code
   string letter_groups [7] = '{"aehiouwy", "bfpv", "cgjkqsxz", "dt", "l", "mn", "r"};

   logic [CHAR_W-1:0] text_q [$];
   sdx_pkg::key_type  stim_key;
   bit                idle_en = 1'b1;
   int                stall_left = 0;
   int                cycle_count = 0;

   always #1 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Mostly short gaps, a few long ones
   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return $urandom_range(1, 3);
      else if (r < 93)
         return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   // Receiver side: random stalls while idling is enabled
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (idle_en && $urandom_range(0, 99) < 15)
            stall_left = gap_cycles();
      end
   end

   function automatic logic [CHAR_W-1:0] mix_case(input logic [CHAR_W-1:0] lc);
      return $urandom_range(0, 1) ? lc - 8'd32 : lc;
   endfunction

   function automatic logic [CHAR_W-1:0] pick_letter(input int grp_sel);
      string grp;
      grp = letter_groups[grp_sel];
      return mix_case(grp[$urandom_range(0, grp.len() - 1)]);
   endfunction

   function automatic sdx_pkg::key_type random_key();
      sdx_pkg::key_type   k;
      int                 n;
      logic [DIGIT_W-1:0] prev;
      logic [DIGIT_W-1:0] d;
      logic [DIGIT_W-1:0] dg [3];
      k.initial_char = CHAR_W'("a" + $urandom_range(0, 25));
      n    = ($urandom_range(0, 9) < 6) ? 3 : $urandom_range(0, 2);
      prev = '0;
      dg   = '{default: '0};
      for (int i = 0; i < n; i++) begin
         do
            d = DIGIT_W'($urandom_range(1, 6));
         while (d == prev);
         dg[i] = d;
         prev  = d;
      end
      k.digit_one   = dg[0];
      k.digit_two   = dg[1];
      k.digit_three = dg[2];
      return k;
   endfunction

   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++)
         text_q.push_back(s[i]);
   endtask

   // Separator run: mostly blanks and punctuation, some raw bytes as noise
   task automatic push_sep();
      int    r;
      int    n;
      string punct;
      punct = " .,;:!?-'()0123456789";
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 40)
            text_q.push_back(" ");
         else if (r < 75)
            text_q.push_back(punct[$urandom_range(0, punct.len() - 1)]);
         else
            text_q.push_back(CHAR_W'($urandom_range(0, 255)));
      end
   endtask

   // Word shaped after the current key; spoil overwrites one of its letters with a random letter
   task automatic push_coded_word(input bit spoil);
      int                 first_idx;
      bit                 stop;
      logic [DIGIT_W-1:0] dg [3];
      logic [CHAR_W-1:0]  init;
      first_idx = text_q.size();
      stop = 1'b0;
      init = (stim_key.initial_char >= "a" && stim_key.initial_char <= "z") ?
             stim_key.initial_char : CHAR_W'("a" + $urandom_range(0, 25));
      text_q.push_back(mix_case(init));
      dg = '{stim_key.digit_one, stim_key.digit_two, stim_key.digit_three};
      for (int i = 0; i < 3; i++) begin
         if (dg[i] == 0 || dg[i] == 7)
            stop = 1'b1;
         if (!stop) begin
            repeat ($urandom_range(0, 2)) text_q.push_back(pick_letter(0));
            repeat ($urandom_range(1, 2)) text_q.push_back(pick_letter(dg[i]));
         end
      end
      if (!stop)
         repeat ($urandom_range(0, 3)) text_q.push_back(pick_letter($urandom_range(0, 6)));
      else
         repeat ($urandom_range(0, 2)) text_q.push_back(pick_letter(0));
      if (spoil)
         text_q[first_idx + $urandom_range(0, text_q.size() - 1 - first_idx)] =
            pick_letter($urandom_range(0, 6));
   endtask

   task automatic push_random_word();
      repeat ($urandom_range(1, 10))
         text_q.push_back(mix_case(CHAR_W'("a" + $urandom_range(0, 25))));
   endtask

   task automatic build_text();
      int words;
      int r;
      text_q.delete();
      if ($urandom_range(0, 3) == 0)
         push_sep();
      words = $urandom_range(1, 5);
      for (int w = 0; w < words; w++) begin
         r = $urandom_range(0, 99);
         if (r < 45)
            push_coded_word(1'b0);
         else if (r < 65)
            push_coded_word(1'b1);
         else
            push_random_word();
         if (w < words - 1 || $urandom_range(0, 1))
            push_sep();
      end
   endtask

   // Hand one character over; starts and returns at a falling edge
   task automatic send_char(input logic [CHAR_W-1:0] ch, input logic fin);
      int gap;
      gap = (idle_en && $urandom_range(0, 99) < 25) ? gap_cycles() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.text_char <= ch;
      req_bus.text_end  <= fin;
      req_bus.valid     <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Send the queued text, the last character closes it
   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++)
         send_char(text_q[i], i == text_q.size() - 1);
   endtask

   // Drop valid, drain every expected result, then let in-flight characters settle
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_key(input sdx_pkg::key_type k);
      logic [CHAR_W-1:0]    vals [4];
      logic [CSR_IDX_W-1:0] idx [4];
      vals = '{k.initial_char, {5'd0, k.digit_one}, {5'd0, k.digit_two},
               {5'd0, k.digit_three}};
      idx  = '{sdx_pkg::REG_KEY_INITIAL, sdx_pkg::REG_KEY_DIGIT_ONE,
               sdx_pkg::REG_KEY_DIGIT_TWO, sdx_pkg::REG_KEY_DIGIT_THREE};
      for (int i = 0; i < 4; i++) begin
         csr_bus.valid     <= 1'b1;
         csr_bus.reg_index <= idx[i];
         csr_bus.wr_data   <= vals[i];
         @(posedge clock);
         while (!csr_bus.ready) @(posedge clock);
         @(negedge clock);
      end
      csr_bus.valid <= 1'b0;
      stim_key = k;
   endtask

   initial begin
      int               sent;
      sdx_pkg::key_type k;
      req_bus.valid     = 1'b0;
      req_bus.text_char = '0;
      req_bus.text_end  = 1'b0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.reg_index = '0;
      csr_bus.wr_data   = '0;
      stim_key          = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: byte extremes, word closed by a non-letter, letter closing the text,
      // text closed outside a word, initial letter not taken as a repeat
      write_key('{"r", 3'd1, 3'd6, 3'd3});
      text_q.delete();
      text_q.push_back(8'h00);
      push_str("Rupert[z");
      text_q.push_back(8'h7F);
      push_str("AZa");
      send_text();
      text_q.delete();
      push_str("@`{");
      text_q.push_back(8'h80);
      text_q.push_back(8'hFF);
      send_text();
      text_q.delete();
      push_str("Rrr.");
      send_text();

      // Random phases, each with its own key
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         case (ph)
            0:       k = '{"a", 3'd0, 3'd0, 3'd0};
            1:       k = '{8'hFF, 3'd7, 3'd7, 3'd7};
            2:       k = '{8'h00, 3'd0, 3'd0, 3'd0};
            9:       k = '{CHAR_W'($urandom_range(0, 255)), DIGIT_W'($urandom_range(0, 7)),
                           DIGIT_W'($urandom_range(0, 7)), DIGIT_W'($urandom_range(0, 7))};
            default: k = random_key();
         endcase
         write_key(k);
         idle_en = (ph % 4 != 3);
         sent = 0;
         while (sent < PHASE_CHARS) begin
            build_text();
            send_text();
            sent += text_q.size();
         end
      end

      // Long text: word length and start position saturate
      wait_idle();
      write_key(random_key());
      idle_en = 1'b0;
      text_q.delete();
      repeat (4100) text_q.push_back(pick_letter($urandom_range(0, 6)));
      push_str(" Tail.");
      send_text();

      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0 && results_pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
